/* hdl/lfg_pkg.sv */
// Shared constants, types and state encodings for the frame rate governor.
package lfg_pkg;

    localparam int COUNTER_BITS = 32;
    localparam int NUM_CNT      = 7;
    localparam int IDX_W        = $clog2(NUM_CNT);
    localparam int TEN_STEPS    = 10;
    localparam int STEP_W       = $clog2(TEN_STEPS + 1);
    localparam int PCT_W        = 7;
    localparam int TGT_W        = 8;
    localparam int MAXF_W       = 7;
    localparam int OVR_W        = 8;
    localparam int CFG_W        = 8;

    localparam logic [IDX_W-1:0]  IDX_IDLE  = IDX_W'(3);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(NUM_CNT - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(TEN_STEPS - 1);
    localparam logic [STEP_W-1:0] STEP_TEN  = STEP_W'(TEN_STEPS);

    localparam logic [PCT_W-1:0] UTIL_HIGH = PCT_W'(90);
    localparam logic [PCT_W-1:0] UTIL_HOLD = PCT_W'(85);
    localparam logic [PCT_W-1:0] UTIL_MID  = PCT_W'(65);
    localparam logic [PCT_W-1:0] PCT_FULL  = PCT_W'(100);
    localparam logic [TGT_W-1:0] STEP_FAST = TGT_W'(2);
    localparam logic [TGT_W-1:0] STEP_SLOW = TGT_W'(1);

    localparam logic [MAXF_W-1:0] MAXF_RST  = MAXF_W'(30);
    localparam logic [OVR_W-1:0]  OVR_RST   = OVR_W'(0);
    localparam logic [TGT_W-1:0]  TGT_RST   = TGT_W'(30);
    localparam logic [TGT_W-1:0]  SAVED_RST = TGT_W'(15);
    localparam logic [1:0]        STREAK_MAX = 2'd3;

    localparam logic CFG_MAX_FPS  = 1'b0;
    localparam logic CFG_OVERRIDE = 1'b1;

    typedef enum logic [2:0] {
        GOV_IDLE,
        GOV_ACCUM,
        GOV_START,
        GOV_WAIT,
        GOV_UPDATE
    } t_gov_state;

    typedef enum logic [2:0] {
        PCT_IDLE,
        PCT_LOOP1,
        PCT_DIFF2,
        PCT_LOOP2,
        PCT_DONE
    } t_pct_state;

    typedef struct packed {
        logic                    start;
        logic [COUNTER_BITS-1:0] busy;
        logic [COUNTER_BITS-1:0] total;
    } t_pct_req;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] pct;
    } t_pct_rsp;

endpackage

/* hdl/lfg_pct_unit.sv */
// Iterative percent: floor(100*busy/total) by two times-ten passes, capped at 100.
module lfg_pct_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lfg_pkg::t_pct_req i_req,
    output lfg_pkg::t_pct_rsp o_rsp
);

    lfg_pkg::t_pct_state r_state, n_state;

    logic [lfg_pkg::COUNTER_BITS-1:0] r_total;
    logic [lfg_pkg::COUNTER_BITS-1:0] r_x;
    logic [lfg_pkg::COUNTER_BITS-1:0] r_d;
    logic [lfg_pkg::COUNTER_BITS-1:0] r_acc;
    logic [lfg_pkg::STEP_W-1:0]       r_cnt;
    logic [lfg_pkg::STEP_W-1:0]       r_q;
    logic [lfg_pkg::STEP_W-1:0]       r_q1;

    logic                             w_ge;
    logic                             w_early;
    logic                             w_busy;

    assign w_ge    = (r_acc >= r_d);
    assign w_early = (i_req.total == '0) || (i_req.busy >= i_req.total);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfg_pkg::PCT_IDLE: begin
                if (i_req.start) begin
                    n_state = w_early ? lfg_pkg::PCT_DONE : lfg_pkg::PCT_LOOP1;
                end
            end
            lfg_pkg::PCT_LOOP1: begin
                if (r_cnt == lfg_pkg::STEP_LAST) begin
                    n_state = lfg_pkg::PCT_DIFF2;
                end
            end
            lfg_pkg::PCT_DIFF2: n_state = lfg_pkg::PCT_LOOP2;
            lfg_pkg::PCT_LOOP2: begin
                if (r_cnt == lfg_pkg::STEP_LAST) begin
                    n_state = lfg_pkg::PCT_DONE;
                end
            end
            lfg_pkg::PCT_DONE: n_state = lfg_pkg::PCT_IDLE;
            default:           n_state = lfg_pkg::PCT_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_rsp.done = 1'b0;
        w_busy     = 1'b0;
        unique case (r_state)
            lfg_pkg::PCT_IDLE:  w_busy     = 1'b0;
            lfg_pkg::PCT_LOOP1: w_busy     = 1'b1;
            lfg_pkg::PCT_DIFF2: w_busy     = 1'b1;
            lfg_pkg::PCT_LOOP2: w_busy     = 1'b1;
            lfg_pkg::PCT_DONE:  o_rsp.done = 1'b1;
            default:            w_busy     = 1'b0;
        endcase
        o_rsp.pct = lfg_pkg::PCT_W'({r_q1, 3'b000}) + lfg_pkg::PCT_W'({r_q1, 1'b0})
                  + lfg_pkg::PCT_W'(r_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfg_pkg::PCT_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Shared add/subtract step: acc >= t - x ? acc - (t - x), q++ : acc + x
    always_ff @(posedge i_clk) begin
        if (r_state == lfg_pkg::PCT_IDLE && i_req.start) begin
            r_total <= i_req.total;
            r_x     <= i_req.busy;
            r_d     <= i_req.total - i_req.busy;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_q     <= '0;
            r_q1    <= (i_req.total != '0 && w_early) ? lfg_pkg::STEP_TEN : '0;
        end else if (r_state == lfg_pkg::PCT_DIFF2) begin
            r_x   <= r_acc;
            r_d   <= r_total - r_acc;
            r_acc <= '0;
            r_cnt <= '0;
            r_q1  <= r_q;
            r_q   <= '0;
        end else if (w_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (w_ge) begin
                r_acc <= r_acc - r_d;
                r_q   <= r_q + 1'b1;
            end else begin
                r_acc <= r_acc + r_x;
            end
        end
    end

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |-> o_rsp.pct <= lfg_pkg::PCT_FULL)
        else $error("percentage above 100");

    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lfg_pkg::PCT_LOOP1 || r_state == lfg_pkg::PCT_LOOP2)
        |-> r_acc < r_total)
        else $error("accumulator reached total");

    a_quot_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lfg_pkg::PCT_DIFF2) |-> r_q <= lfg_pkg::STEP_LAST)
        else $error("first digit above nine");

endmodule

/* hdl/load_driven_frame_rate_governor.sv */
// Top level: counter deltas, governor update, config registers and result register.
// Sequence: after accept, a delta pass over all counters, a start step, the divider's
//   passes and its done state, then the update; the divider skips its passes when the
//   total is zero or busy reaches the total. o_ready is high only when idle, so a new
//   request waits for the update, which stalls while the output holds an untaken result.
// Reset (synchronous, active low): counters zero, target 30, saved 15, max_fps 30.
module load_driven_frame_rate_governor (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [31:0]               i_user_ticks,
    input  logic [31:0]               i_nice_ticks,
    input  logic [31:0]               i_system_ticks,
    input  logic [31:0]               i_idle_ticks,
    input  logic [31:0]               i_iowait_ticks,
    input  logic [31:0]               i_hardirq_ticks,
    input  logic [31:0]               i_softirq_ticks,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [6:0]                o_utilization,
    output logic [6:0]                o_target_rate,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [lfg_pkg::CFG_W-1:0] i_cfg_data
);

    lfg_pkg::t_gov_state r_state, n_state;

    logic [lfg_pkg::COUNTER_BITS-1:0] r_sample [lfg_pkg::NUM_CNT];
    logic [lfg_pkg::COUNTER_BITS-1:0] r_prev   [lfg_pkg::NUM_CNT];
    logic [lfg_pkg::COUNTER_BITS-1:0] r_busy;
    logic [lfg_pkg::COUNTER_BITS-1:0] r_total;
    logic [lfg_pkg::COUNTER_BITS-1:0] w_delta;
    logic [lfg_pkg::IDX_W-1:0]        r_idx;

    logic [lfg_pkg::MAXF_W-1:0] r_max_fps;
    logic [lfg_pkg::OVR_W-1:0]  r_frames_override;
    logic [lfg_pkg::PCT_W-1:0]  r_prev_util;
    logic [1:0]                 r_streak;
    logic [lfg_pkg::TGT_W-1:0]  r_cur_target;
    logic [lfg_pkg::TGT_W-1:0]  r_saved;
    logic [lfg_pkg::PCT_W-1:0]  r_out_util;
    logic [lfg_pkg::TGT_W-1:0]  r_out_target;
    logic                       r_out_valid;

    lfg_pkg::t_pct_req w_req;
    lfg_pkg::t_pct_rsp w_rsp;

    logic                       w_accept;
    logic                       w_accum;
    logic                       w_start;
    logic                       w_slot_free;
    logic                       w_update;
    logic [lfg_pkg::PCT_W-1:0]  w_util;
    logic [lfg_pkg::TGT_W-1:0]  w_target;
    logic [lfg_pkg::TGT_W-1:0]  w_saved;
    logic [1:0]                 w_streak;
    logic [1:0]                 w_streak_inc;
    logic [lfg_pkg::TGT_W-1:0]  w_maxf;
    logic [lfg_pkg::TGT_W-1:0]  w_final;

    assign w_accept    = i_valid && o_ready;
    assign w_slot_free = !r_out_valid || i_ready;
    assign w_update    = (r_state == lfg_pkg::GOV_UPDATE) && w_slot_free;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfg_pkg::GOV_IDLE: begin
                if (i_valid) begin
                    n_state = lfg_pkg::GOV_ACCUM;
                end
            end
            lfg_pkg::GOV_ACCUM: begin
                if (r_idx == lfg_pkg::IDX_LAST) begin
                    n_state = lfg_pkg::GOV_START;
                end
            end
            lfg_pkg::GOV_START: n_state = lfg_pkg::GOV_WAIT;
            lfg_pkg::GOV_WAIT: begin
                if (w_rsp.done) begin
                    n_state = lfg_pkg::GOV_UPDATE;
                end
            end
            lfg_pkg::GOV_UPDATE: begin
                if (w_slot_free) begin
                    n_state = lfg_pkg::GOV_IDLE;
                end
            end
            default: n_state = lfg_pkg::GOV_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_ready = 1'b0;
        w_accum = 1'b0;
        w_start = 1'b0;
        unique case (r_state)
            lfg_pkg::GOV_IDLE:   o_ready = 1'b1;
            lfg_pkg::GOV_ACCUM:  w_accum = 1'b1;
            lfg_pkg::GOV_START:  w_start = 1'b1;
            lfg_pkg::GOV_WAIT:   o_ready = 1'b0;
            lfg_pkg::GOV_UPDATE: o_ready = 1'b0;
            default:             o_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfg_pkg::GOV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fps         <= lfg_pkg::MAXF_RST;
            r_frames_override <= lfg_pkg::OVR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lfg_pkg::CFG_MAX_FPS:  r_max_fps <= i_cfg_data[lfg_pkg::MAXF_W-1:0];
                lfg_pkg::CFG_OVERRIDE: r_frames_override <= i_cfg_data[lfg_pkg::OVR_W-1:0];
                default:               r_max_fps <= r_max_fps;
            endcase
        end
    end

    // Samples and previous counters rotate through slot 0, one counter per cycle
    assign w_delta = r_sample[0] - r_prev[0];

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample[0] <= i_user_ticks[lfg_pkg::COUNTER_BITS-1:0];
            r_sample[1] <= i_nice_ticks[lfg_pkg::COUNTER_BITS-1:0];
            r_sample[2] <= i_system_ticks[lfg_pkg::COUNTER_BITS-1:0];
            r_sample[3] <= i_idle_ticks[lfg_pkg::COUNTER_BITS-1:0];
            r_sample[4] <= i_iowait_ticks[lfg_pkg::COUNTER_BITS-1:0];
            r_sample[5] <= i_hardirq_ticks[lfg_pkg::COUNTER_BITS-1:0];
            r_sample[6] <= i_softirq_ticks[lfg_pkg::COUNTER_BITS-1:0];
            r_busy      <= '0;
            r_total     <= '0;
        end else if (w_accum) begin
            for (int k = 0; k < lfg_pkg::NUM_CNT - 1; k++) begin
                r_sample[k] <= r_sample[k+1];
            end
            r_sample[lfg_pkg::NUM_CNT-1] <= r_sample[0];
            r_total <= r_total + w_delta;
            if (r_idx != lfg_pkg::IDX_IDLE) begin
                r_busy <= r_busy + w_delta;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            for (int k = 0; k < lfg_pkg::NUM_CNT; k++) begin
                r_prev[k] <= '0;
            end
        end else if (w_accum) begin
            r_idx <= (r_idx == lfg_pkg::IDX_LAST) ? '0 : r_idx + 1'b1;
            for (int k = 0; k < lfg_pkg::NUM_CNT - 1; k++) begin
                r_prev[k] <= r_prev[k+1];
            end
            r_prev[lfg_pkg::NUM_CNT-1] <= r_sample[0];
        end
    end

    assign w_req.start = w_start;
    assign w_req.busy  = r_busy;
    assign w_req.total = r_total;

    lfg_pct_unit u_pct (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Governor update
    always_comb begin
        w_util       = (w_rsp.pct == '0) ? r_prev_util : w_rsp.pct;
        w_streak_inc = (r_streak == lfg_pkg::STREAK_MAX) ? r_streak : r_streak + 1'b1;
        w_target     = r_cur_target;
        w_saved      = r_cur_target;
        w_streak     = '0;
        if (w_util >= lfg_pkg::UTIL_HOLD && w_util <= lfg_pkg::UTIL_HIGH) begin
            w_target = r_cur_target;
        end else if (w_util > lfg_pkg::UTIL_HIGH) begin
            w_streak = w_streak_inc;
            w_saved  = r_saved;
            w_target = (w_streak_inc < 2'd2) ? r_saved : (r_cur_target >> 1);
        end else if (w_util >= lfg_pkg::UTIL_MID) begin
            w_target = r_cur_target + lfg_pkg::STEP_SLOW;
        end else begin
            w_target = r_cur_target + lfg_pkg::STEP_FAST;
        end
        w_maxf  = lfg_pkg::TGT_W'(r_max_fps);
        w_final = (w_target > w_maxf || r_frames_override > w_maxf) ? w_maxf : w_target;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_util  <= '0;
            r_streak     <= '0;
            r_cur_target <= lfg_pkg::TGT_RST;
            r_saved      <= lfg_pkg::SAVED_RST;
        end else if (w_update) begin
            r_prev_util  <= w_util;
            r_streak     <= w_streak;
            r_cur_target <= w_final;
            r_saved      <= w_saved;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_update) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_out_util   <= w_util;
            r_out_target <= w_final;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_utilization = r_out_util;
    assign o_target_rate = r_out_target[6:0];

    a_target_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_out_target <= lfg_pkg::TGT_W'(r_max_fps))
        else $error("target above max_fps");

    a_util_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_utilization <= lfg_pkg::PCT_FULL)
        else $error("utilization above 100");

    a_streak_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_streak != 2'd0) |-> r_prev_util > lfg_pkg::UTIL_HIGH)
        else $error("overload streak without overload");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == lfg_pkg::GOV_ACCUM && r_idx == '0))
        else $error("accepted request did not start delta pass");

endmodule

/* bench/load_driven_frame_rate_governor_test.sv */
`timescale 1ns / 100ps
// Testbench for load_driven_frame_rate_governor: counter samples in, checked results out.
module load_driven_frame_rate_governor_test;

    localparam int CLK_PERIOD    = 4;
    localparam int RST_CYCLES    = 10;
    localparam int SETTLE_CYCLES = 40;
    localparam int WATCHDOG_MAX  = 5000;
    localparam int IDLE_PCT      = 16;
    localparam int HOLD_AT       = 370;
    localparam int HOLD_LEN      = 600;
    localparam int PHASE_ITEMS   = 100;
    localparam int NUM_PHASES    = 8;

    typedef bit [lfg_pkg::NUM_CNT-1:0][31:0] t_sample;

    typedef struct packed {
        bit [lfg_pkg::PCT_W-1:0] util;
        bit [6:0]                rate;
    } t_rate_result;

    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      i_valid         = 1'b0;
    logic                      o_ready;
    logic [31:0]               i_user_ticks    = '0;
    logic [31:0]               i_nice_ticks    = '0;
    logic [31:0]               i_system_ticks  = '0;
    logic [31:0]               i_idle_ticks    = '0;
    logic [31:0]               i_iowait_ticks  = '0;
    logic [31:0]               i_hardirq_ticks = '0;
    logic [31:0]               i_softirq_ticks = '0;
    logic                      o_valid;
    logic                      i_ready         = 1'b0;
    logic [6:0]                o_utilization;
    logic [6:0]                o_target_rate;
    logic                      i_cfg_we        = 1'b0;
    logic                      i_cfg_idx       = lfg_pkg::CFG_MAX_FPS;
    logic [lfg_pkg::CFG_W-1:0] i_cfg_data      = '0;

    // stimulus side
    t_sample      sample_q[$];
    t_sample      stim_sample  = '0;
    t_sample      tx_sample;
    int           queued_cnt   = 0;
    int           sent_cnt     = 0;
    bit           steady       = 1'b0;

    // governor model state
    t_sample                    last_sample  = '0;
    bit [lfg_pkg::PCT_W-1:0]    last_util    = '0;
    bit [1:0]                   overload_run = '0;
    bit [lfg_pkg::TGT_W-1:0]    cur_rate     = lfg_pkg::TGT_RST;
    bit [lfg_pkg::TGT_W-1:0]    saved_rate   = lfg_pkg::SAVED_RST;
    bit [lfg_pkg::MAXF_W-1:0]   max_rate     = lfg_pkg::MAXF_RST;
    bit [lfg_pkg::OVR_W-1:0]    frames_ovr   = lfg_pkg::OVR_RST;
    t_rate_result               rate_exp[$];

    // result side
    t_rate_result want;
    int           results_seen = 0;
    int           hold_left    = 0;
    bit           hold_done    = 1'b0;
    int           err_cnt      = 0;
    int           quiet_cycles = 0;

    load_driven_frame_rate_governor uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_user_ticks    (i_user_ticks),
        .i_nice_ticks    (i_nice_ticks),
        .i_system_ticks  (i_system_ticks),
        .i_idle_ticks    (i_idle_ticks),
        .i_iowait_ticks  (i_iowait_ticks),
        .i_hardirq_ticks (i_hardirq_ticks),
        .i_softirq_ticks (i_softirq_ticks),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_utilization   (o_utilization),
        .o_target_rate   (o_target_rate),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void predict_rate(input t_sample s);
        bit [31:0] d;
        bit [31:0] busy;
        bit [31:0] total;
        int        util;
        int        rate;
        busy  = '0;
        total = '0;
        for (int k = 0; k < lfg_pkg::NUM_CNT; k++) begin
            d     = s[k] - last_sample[k];
            total = total + d;
            if (k != lfg_pkg::IDX_IDLE)
                busy = busy + d;
        end
        last_sample = s;

        if (total == 0)
            util = 0;
        else if (busy >= total)
            util = lfg_pkg::PCT_FULL;
        else
            util = int'((64'(busy) * lfg_pkg::PCT_FULL) / total);
        if (util == 0)
            util = last_util;
        last_util = util[lfg_pkg::PCT_W-1:0];

        rate = cur_rate;
        if (util > lfg_pkg::UTIL_HIGH) begin
            if (overload_run != lfg_pkg::STREAK_MAX)
                overload_run++;
            rate = (overload_run < 2) ? int'(saved_rate) : rate / 2;
        end else begin
            overload_run = '0;
            saved_rate   = cur_rate;
            if (util < lfg_pkg::UTIL_MID)
                rate = rate + lfg_pkg::STEP_FAST;
            else if (util < lfg_pkg::UTIL_HOLD)
                rate = rate + lfg_pkg::STEP_SLOW;
        end
        if (rate > max_rate || frames_ovr > max_rate)
            rate = max_rate;
        cur_rate = rate[lfg_pkg::TGT_W-1:0];

        rate_exp.push_back('{util: util[lfg_pkg::PCT_W-1:0], rate: cur_rate[6:0]});
    endfunction

    task automatic push_sample(input t_sample s);
        sample_q.push_back(s);
        stim_sample = s;
        queued_cnt++;
    endtask

    task automatic add_deltas(input t_sample d);
        t_sample s;
        for (int k = 0; k < lfg_pkg::NUM_CNT; k++)
            s[k] = stim_sample[k] + d[k];
        push_sample(s);
    endtask

    // busy share of total split at random over the six busy counters
    task automatic add_load(input int pct, input bit [31:0] total);
        t_sample   d;
        bit [31:0] busy;
        bit [31:0] left;
        busy = 32'((64'(total) * pct) / 100);
        left = busy;
        for (int k = 0; k < lfg_pkg::NUM_CNT; k++) begin
            if (k == lfg_pkg::IDX_IDLE) begin
                d[k] = total - busy;
            end else if (k == lfg_pkg::NUM_CNT - 1) begin
                d[k] = left;
            end else begin
                d[k] = $urandom_range(left, 0);
                left = left - d[k];
            end
        end
        add_deltas(d);
    endtask

    task automatic wait_drained();
        while (sent_cnt != queued_cnt || rate_exp.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input bit [lfg_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == lfg_pkg::CFG_MAX_FPS)
            max_rate = val[lfg_pkg::MAXF_W-1:0];
        else
            frames_ovr = val[lfg_pkg::OVR_W-1:0];
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_rate({i_softirq_ticks, i_hardirq_ticks, i_iowait_ticks, i_idle_ticks,
                              i_system_ticks, i_nice_ticks, i_user_ticks});
                sent_cnt++;
            end
            if (!i_valid || o_ready) begin
                if (sample_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    tx_sample        = sample_q.pop_front();
                    i_user_ticks    <= tx_sample[0];
                    i_nice_ticks    <= tx_sample[1];
                    i_system_ticks  <= tx_sample[2];
                    i_idle_ticks    <= tx_sample[3];
                    i_iowait_ticks  <= tx_sample[4];
                    i_hardirq_ticks <= tx_sample[5];
                    i_softirq_ticks <= tx_sample[6];
                    i_valid         <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and ready generation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (rate_exp.size() == 0) begin
                    $error("unexpected result: utilization %0d, target_rate %0d",
                           o_utilization, o_target_rate);
                    err_cnt++;
                end else begin
                    want = rate_exp.pop_front();
                    if (o_utilization !== want.util) begin
                        $error("utilization: expected %0d, actual %0d", want.util, o_utilization);
                        err_cnt++;
                    end
                    if (o_target_rate !== want.rate) begin
                        $error("target_rate: expected %0d, actual %0d", want.rate, o_target_rate);
                        err_cnt++;
                    end
                end
                results_seen++;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (results_seen == HOLD_AT && !hold_done) begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
                i_ready  <= 1'b0;
            end else begin
                i_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_MAX) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_sample                   raw;
        bit [lfg_pkg::CFG_W-1:0]   max_val;
        bit [lfg_pkg::CFG_W-1:0]   ovr_val;
        int                        pick;
        int                        band;
        int                        pct;
        bit [31:0]                 total;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, at reset settings
        add_deltas('0);
        add_load(50, 1000);
        add_load(0, 500);
        add_load(64, 100);
        add_load(65, 200);
        add_load(84, 300);
        add_load(85, 100);
        add_load(90, 100);
        add_load(91, 100);
        add_load(100, 400);
        add_load(95, 100);
        add_load(99, 100);
        add_load(88, 100);
        add_load(92, 100);
        // sums wrap so busy exceeds total
        raw = '0;
        raw[0]                = 32'h9000_0000;
        raw[lfg_pkg::IDX_IDLE] = 32'h8000_0000;
        add_deltas(raw);
        push_sample('1);
        push_sample('1);
        push_sample('0);
        add_load(30, 1000);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin max_val = 120;   ovr_val = 0;   end
                1: begin max_val = 1;     ovr_val = 0;   end
                2: begin max_val = 0;     ovr_val = 0;   end
                3: begin max_val = 8'hFF; ovr_val = 0;   end
                4: begin max_val = 60;    ovr_val = 200; end
                5: begin max_val = 120;   ovr_val = 255; end
                6: begin max_val = 45;    ovr_val = 45;  end
                default: begin max_val = 100; ovr_val = 101; end
            endcase
            write_reg(lfg_pkg::CFG_MAX_FPS, max_val);
            write_reg(lfg_pkg::CFG_OVERRIDE, ovr_val);
            steady = (p == 1);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    band = $urandom_range(99);
                    if (band < 35)
                        pct = $urandom_range(100, 91);
                    else if (band < 55)
                        pct = $urandom_range(90, 85);
                    else if (band < 75)
                        pct = $urandom_range(84, 65);
                    else
                        pct = $urandom_range(64, 0);
                    if ($urandom_range(3) == 0)
                        total = $urandom_range(32'h3FFF_FFFF, 1);
                    else
                        total = $urandom_range(2000, 1);
                    add_load(pct, total);
                end else if (pick < 78) begin
                    add_deltas('0);
                end else begin
                    for (int k = 0; k < lfg_pkg::NUM_CNT; k++)
                        raw[k] = $urandom();
                    if (pick < 90)
                        push_sample(raw);
                    else
                        add_deltas(raw);
                end
            end
            wait_drained();
        end
        steady = 1'b0;

        if (err_cnt == 0 && rate_exp.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
